[src/bdcc_pkg.sv]
// ----------------------------------------------------------------------------
// bdcc_pkg
// shared types and constants for the button debounce and click counter
// ----------------------------------------------------------------------------
package bdcc_pkg;

   localparam int unsigned DEBOUNCE_W = 8;
   localparam int unsigned TIMEOUT_W  = 16;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned CLICK_W    = 8;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 16;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd80;
   localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET  = 16'd500;
   localparam logic [CLICK_W-1:0]    CLICK_MAX      = 8'd255;

   typedef enum logic [0:0] {
      REG_DEBOUNCE = 1'b0,
      REG_TIMEOUT  = 1'b1
   } reg_index_type;

   // result item, lowest bit first: pressed_now .. click_count
   typedef struct packed {
      logic [CLICK_W-1:0] click_count;
      logic               clicks_pending;
      logic               held_pending;
      logic               release_pending;
      logic               press_pending;
      logic               pressed_now;
   } result_type;

   localparam int unsigned RESULT_W = $bits(result_type);

endpackage

[src/button_debounce_click_counter_core.sv]
// ----------------------------------------------------------------------------
// button_debounce_click_counter_core
// debounced press, release, long press and multi-click detection
// ----------------------------------------------------------------------------
// each response is registered in the response buffer and read from its head on rsp_tdata
// throughput: one sample per cycle while req_tready is high; state updates on each accepted sample
// a two-entry response buffer keeps req_tready high while one response waits
// reset: synchronous, clears press state, flags and buffer count, loads debounce 80, timeout 500
// ----------------------------------------------------------------------------
module button_debounce_click_counter_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [bdcc_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // pin_level, now_ms[32], ack_press, ack_release, ack_held, ack_clicks, zero fill
   input  logic [bdcc_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // pressed_now, press_pending, release_pending, held_pending, clicks_pending,
   // click_count[8], zero fill
   output logic [bdcc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import bdcc_pkg::*;

   logic [DEBOUNCE_W-1:0] debounce_ff;
   logic [TIMEOUT_W-1:0]  timeout_ff;

   logic                  press_latched_ff, press_latched_in;
   logic                  long_press_ff, long_press_in;
   logic [TIME_W-1:0]     last_press_ff, last_press_in;
   logic [CLICK_W-1:0]    clicks_ff, clicks_in;
   logic [CLICK_W-1:0]    series_count_ff, series_count_in;
   logic                  press_flag_ff, press_flag_in;
   logic                  release_flag_ff, release_flag_in;
   logic                  held_flag_ff, held_flag_in;
   logic                  done_flag_ff, done_flag_in;

   result_type            head_ff, head_in;
   result_type            tail_ff, tail_in;
   logic [1:0]            count_ff, count_in;

   logic                  push, pop, slot;
   logic                  pressed, ack_press, ack_release, ack_held, ack_clicks;
   logic [TIME_W-1:0]     now, elapsed;
   logic                  gt_debounce, gt_timeout;
   logic                  take_press, take_release, take_hold, take_done;
   logic [CLICK_W-1:0]    clicks_a, clicks_b;
   result_type            result;

   assign pressed     = ~req_tdata[0];
   assign now         = req_tdata[32:1];
   assign ack_press   = req_tdata[33];
   assign ack_release = req_tdata[34];
   assign ack_held    = req_tdata[35];
   assign ack_clicks  = req_tdata[36];

   assign elapsed     = now - last_press_ff;
   assign gt_debounce = elapsed > {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_ff};
   assign gt_timeout  = elapsed > {{(TIME_W-TIMEOUT_W){1'b0}}, timeout_ff};

   assign push = req_tvalid & req_tready;
   assign pop  = rsp_tvalid & rsp_tready;

   // sample update
   always_comb begin
      take_press   = pressed & ~press_latched_ff & gt_debounce;
      take_release = ~pressed & press_latched_ff;
      // an accepted press restarts elapsed time at zero
      take_hold    = press_latched_ff & pressed & ~long_press_ff & gt_timeout;
      clicks_a     = (take_press && clicks_ff != CLICK_MAX) ? clicks_ff + 1'b1 : clicks_ff;
      clicks_b     = take_hold ? '0 : clicks_a;
      take_done    = ~take_press & gt_timeout & (clicks_b != '0);

      press_latched_in = (press_latched_ff | take_press) & ~take_release;
      long_press_in    = (long_press_ff & ~take_release) | take_hold;
      last_press_in    = take_press ? now : last_press_ff;
      clicks_in        = take_done ? '0 : clicks_b;
      series_count_in  = take_done ? clicks_b : series_count_ff;
      press_flag_in    = (press_flag_ff & ~ack_press) | take_press;
      release_flag_in  = (release_flag_ff & ~ack_release) | take_release;
      held_flag_in     = (held_flag_ff & ~ack_held) | take_hold;
      done_flag_in     = (done_flag_ff & ~ack_clicks) | take_done;

      result.pressed_now     = pressed;
      result.press_pending   = press_flag_in;
      result.release_pending = release_flag_in;
      result.held_pending    = held_flag_in;
      result.clicks_pending  = done_flag_in;
      result.click_count     = series_count_in;
   end

   // response buffer
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      slot     = count_ff[1] | (count_ff[0] & ~pop);
      if (pop) begin
         head_in = tail_ff;
      end
      if (push) begin
         if (slot) begin
            tail_in = result;
         end else begin
            head_in = result;
         end
      end
   end

   assign req_tready = ~count_ff[1];
   assign rsp_tvalid = count_ff != 2'd0;
   assign rsp_tdata  = {{(RSP_DATA_W-RESULT_W){1'b0}}, head_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff      <= DEBOUNCE_RESET;
         timeout_ff       <= TIMEOUT_RESET;
         press_latched_ff <= 1'b0;
         long_press_ff    <= 1'b0;
         last_press_ff    <= '0;
         clicks_ff        <= '0;
         series_count_ff  <= '0;
         press_flag_ff    <= 1'b0;
         release_flag_ff  <= 1'b0;
         held_flag_ff     <= 1'b0;
         done_flag_ff     <= 1'b0;
         count_ff         <= 2'd0;
      end else begin
         if (csr_we) begin
            unique case (reg_index_type'(csr_index))
               REG_DEBOUNCE: debounce_ff <= csr_wdata[DEBOUNCE_W-1:0];
               REG_TIMEOUT:  timeout_ff  <= csr_wdata[TIMEOUT_W-1:0];
               default:      ;
            endcase
         end
         if (push) begin
            press_latched_ff <= press_latched_in;
            long_press_ff    <= long_press_in;
            last_press_ff    <= last_press_in;
            clicks_ff        <= clicks_in;
            series_count_ff  <= series_count_in;
            press_flag_ff    <= press_flag_in;
            release_flag_ff  <= release_flag_in;
            held_flag_ff     <= held_flag_in;
            done_flag_ff     <= done_flag_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("response buffer overfilled");

   a_long_needs_latch: assert property (@(posedge clock) disable iff (reset)
      !press_latched_ff |-> !long_press_ff)
      else $error("long press without latched press");

   a_done_count: assert property (@(posedge clock) disable iff (reset)
      done_flag_ff |-> series_count_ff != '0)
      else $error("series done with empty count");

   a_hold_flag: assert property (@(posedge clock) disable iff (reset)
      push && take_hold |=> held_flag_ff && clicks_ff == '0)
      else $error("hold not recorded");

endmodule
